[rtl/core/ffha_pkg.sv]
package ffha_pkg;

  localparam int ADDR_W = 10;
  localparam int BYTE_W = 8;
  localparam int MEM_DEPTH = 256;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;

  // heap store access, one per cycle
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    U_IDLE,
    U_A_HDR,
    U_A_SIZE,
    U_A_LDBS,
    U_A_TEST,
    U_A_ADV,
    U_A_TAKE,
    U_A_SPLIT0,
    U_A_SPLIT1,
    U_A_SPLIT2,
    U_A_OK,
    U_A_NOFIT,
    U_F_CLR,
    U_F_RDSZ,
    U_F_LDBS,
    U_F_HDR,
    U_F_SIZE,
    U_F_TEST,
    U_F_GROW,
    U_F_STORE,
    U_F_DONE
  } step_t;

  typedef enum logic [2:0] {
    A_CUR,
    A_CUR1,
    A_NH,
    A_NH1,
    A_NXT,
    A_NXT1
  } addr_sel_t;

  typedef enum logic [2:0] {
    W_ZERO,
    W_ONE,
    W_REQ,
    W_REM,
    W_BS
  } wdat_sel_t;

  typedef enum logic [2:0] {
    L_NONE,
    L_FLAG,
    L_BS,
    L_BSADD,
    L_CURADV
  } ld_sel_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_CUR_END,
    C_FIT,
    C_NOSPLIT,
    C_NXT_END,
    C_FLAG_SET,
    C_DISPATCH,
    C_EMIT
  } cond_t;

  typedef enum logic [1:0] {
    R_OK,
    R_NOFIT,
    R_FREED
  } res_sel_t;

  typedef struct packed {
    addr_sel_t asel;
    logic      rd;
    logic      wr;
    wdat_sel_t wsel;
    ld_sel_t   ld;
    cond_t     cond;
    res_sel_t  res;
    step_t     target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    asel:   A_CUR,
    rd:     1'b0,
    wr:     1'b0,
    wsel:   W_ZERO,
    ld:     L_NONE,
    cond:   C_NEXT,
    res:    R_OK,
    target: U_IDLE
  };

  // microprogram store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (s)
      U_IDLE: begin
        c.cond = C_DISPATCH;
      end
      U_A_HDR: begin
        c.rd     = 1'b1;
        c.asel   = A_CUR;
        c.cond   = C_CUR_END;
        c.target = U_A_NOFIT;
      end
      U_A_SIZE: begin
        c.rd   = 1'b1;
        c.asel = A_CUR1;
        c.ld   = L_FLAG;
      end
      U_A_LDBS: begin
        c.ld = L_BS;
      end
      U_A_TEST: begin
        c.cond   = C_FIT;
        c.target = U_A_TAKE;
      end
      U_A_ADV: begin
        c.ld     = L_CURADV;
        c.cond   = C_ALWAYS;
        c.target = U_A_HDR;
      end
      U_A_TAKE: begin
        c.wr     = 1'b1;
        c.asel   = A_CUR;
        c.wsel   = W_ONE;
        c.cond   = C_NOSPLIT;
        c.target = U_A_OK;
      end
      U_A_SPLIT0: begin
        c.wr   = 1'b1;
        c.asel = A_CUR1;
        c.wsel = W_REQ;
      end
      U_A_SPLIT1: begin
        c.wr   = 1'b1;
        c.asel = A_NH;
        c.wsel = W_ZERO;
      end
      U_A_SPLIT2: begin
        c.wr   = 1'b1;
        c.asel = A_NH1;
        c.wsel = W_REM;
      end
      U_A_OK: begin
        c.cond = C_EMIT;
        c.res  = R_OK;
      end
      U_A_NOFIT: begin
        c.cond = C_EMIT;
        c.res  = R_NOFIT;
      end
      U_F_CLR: begin
        c.wr   = 1'b1;
        c.asel = A_CUR;
        c.wsel = W_ZERO;
      end
      U_F_RDSZ: begin
        c.rd   = 1'b1;
        c.asel = A_CUR1;
      end
      U_F_LDBS: begin
        c.ld = L_BS;
      end
      U_F_HDR: begin
        c.rd     = 1'b1;
        c.asel   = A_NXT;
        c.cond   = C_NXT_END;
        c.target = U_F_DONE;
      end
      U_F_SIZE: begin
        c.rd   = 1'b1;
        c.asel = A_NXT1;
        c.ld   = L_FLAG;
      end
      U_F_TEST: begin
        c.cond   = C_FLAG_SET;
        c.target = U_F_DONE;
      end
      U_F_GROW: begin
        c.ld = L_BSADD;
      end
      U_F_STORE: begin
        c.wr     = 1'b1;
        c.asel   = A_CUR1;
        c.wsel   = W_BS;
        c.cond   = C_ALWAYS;
        c.target = U_F_HDR;
      end
      U_F_DONE: begin
        c.cond = C_EMIT;
        c.res  = R_FREED;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/core/ffha_store.sv]
module ffha_store #(
  parameter int HEAP_BASE  = 128,
  parameter int HEAP_LIMIT = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ffha_pkg::mem_req_t               req,
  output logic [ffha_pkg::BYTE_W-1:0]      rdata
);
  import ffha_pkg::*;

  localparam logic [BYTE_W-1:0] INIT_SIZE = BYTE_W'(HEAP_LIMIT - HEAP_BASE - 2);
  localparam logic [ADDR_W-1:0] BASE_A    = ADDR_W'(HEAP_BASE);
  localparam logic [ADDR_W-1:0] LIMIT_A   = ADDR_W'(HEAP_LIMIT);
  localparam logic [ADDR_W-1:0] SIZE_A    = ADDR_W'(HEAP_BASE + 1);
  localparam logic [ADDR_W-1:0] TOP_A     = ADDR_W'(MEM_DEPTH);

  logic [BYTE_W-1:0] heap_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic rd_vld_r;
  logic rd_inh_r;
  logic rd_init_r;
  logic inh;
  logic [7:0] idx;

  assign idx = req.addr[7:0];
  assign inh = (req.addr >= BASE_A) && (req.addr < LIMIT_A) && (req.addr < TOP_A);

  always_ff @(posedge clk) begin
    if (req.we && inh) begin
      heap_mem[idx] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= heap_mem[idx];
    end
  end

  // unwritten bytes read as the reset image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_inh_r  <= 1'b0;
      rd_init_r <= 1'b0;
    end else begin
      if (req.we && inh) begin
        vld_r[idx] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r  <= vld_r[idx];
        rd_inh_r  <= inh;
        rd_init_r <= (req.addr == SIZE_A);
      end
    end
  end

  always_comb begin
    if (!rd_inh_r) begin
      rdata = '0;
    end else if (rd_vld_r) begin
      rdata = rd_data_r;
    end else if (rd_init_r) begin
      rdata = INIT_SIZE;
    end else begin
      rdata = '0;
    end
  end

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// sequence from accept to out_valid: allocate runs header, size, load, test and advance
//   steps per header passed over, then ends at no fit, takes the whole block, or splits it;
//   free clears, reads its size, merges each free neighbor, then stops at the heap end or a
//   used block; a stalled result holds its finishing step. One transaction at a time, the
//   next accepted back in idle; worst case is a wild free merging two bytes at a time from 0
// reset: synchronous active-low; heap reads as one free block at once via per-byte valid bits
module first_fit_heap_allocator #(
  parameter int HEAP_BASE  = 128,
  parameter int HEAP_LIMIT = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_request_size,
  input  logic [7:0] in_release_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_address,
  output logic [1:0] out_status
);
  import ffha_pkg::*;

  localparam logic [ADDR_W-1:0] BASE_A  = ADDR_W'(HEAP_BASE);
  localparam logic [ADDR_W-1:0] LIMIT_A = ADDR_W'(HEAP_LIMIT);

  // sequencer state
  step_t upc_r, upc_nxt;
  logic  out_valid_r, out_valid_nxt;

  // datapath registers
  logic [ADDR_W-1:0] cur_r, cur_nxt;    // header being examined / freed
  logic [ADDR_W-1:0] bs_r, bs_nxt;      // block size, full width while merging
  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] req_r, req_nxt;
  logic [7:0]        paddr_r, paddr_nxt;
  logic [1:0]        status_r, status_nxt;

  ctrl_t             cw;
  mem_req_t          mreq;
  logic [BYTE_W-1:0] rdata;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W-1:0] nh_addr;
  logic [ADDR_W-1:0] req_w;
  logic              fit;
  logic              split;
  logic              taken;
  logic              in_acc;
  logic              out_busy;
  logic              emit_go;

  ffha_store #(
    .HEAP_BASE  (HEAP_BASE),
    .HEAP_LIMIT (HEAP_LIMIT)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (rdata)
  );

  // control word for the current step
  assign cw = ucode(upc_r);

  assign req_w    = {2'b00, req_r};
  assign nxt_addr = cur_r + bs_r + ADDR_W'(2);     // header after the current block
  assign nh_addr  = cur_r + req_w + ADDR_W'(2);    // header of the split remainder
  assign fit      = (flag_r == '0) && (req_w <= bs_r);
  assign split    = (bs_r >= ADDR_W'(2)) && (req_w < bs_r - ADDR_W'(2));

  assign in_ready = (upc_r == U_IDLE);
  assign in_acc   = in_valid && in_ready;
  // output register frees up when its transaction goes out
  assign out_busy = out_valid_r && !out_ready;
  assign emit_go  = (cw.cond == C_EMIT) && !out_busy;

  // conditional jump decode
  always_comb begin
    unique case (cw.cond)
      C_NEXT:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_CUR_END:  taken = (cur_r >= LIMIT_A);
      C_FIT:      taken = fit;
      C_NOSPLIT:  taken = !split;
      C_NXT_END:  taken = (nxt_addr >= LIMIT_A);
      C_FLAG_SET: taken = (flag_r != '0);
      default:    taken = 1'b0;
    endcase
  end

  // heap store access
  always_comb begin
    mreq.re = cw.rd;
    mreq.we = cw.wr;
    unique case (cw.asel)
      A_CUR:   mreq.addr = cur_r;
      A_CUR1:  mreq.addr = cur_r + ADDR_W'(1);
      A_NH:    mreq.addr = nh_addr;
      A_NH1:   mreq.addr = nh_addr + ADDR_W'(1);
      A_NXT:   mreq.addr = nxt_addr;
      A_NXT1:  mreq.addr = nxt_addr + ADDR_W'(1);
      default: mreq.addr = cur_r;
    endcase
    unique case (cw.wsel)
      W_ZERO:  mreq.wdata = '0;
      W_ONE:   mreq.wdata = BYTE_W'(1);
      W_REQ:   mreq.wdata = req_r;
      W_REM:   mreq.wdata = bs_r[7:0] - req_r - BYTE_W'(2);
      W_BS:    mreq.wdata = bs_r[7:0];   // merged size keeps its low byte
      default: mreq.wdata = '0;
    endcase
  end

  // next-state and datapath
  always_comb begin
    upc_nxt       = upc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cur_nxt       = cur_r;
    bs_nxt        = bs_r;
    flag_nxt      = flag_r;
    req_nxt       = req_r;
    paddr_nxt     = paddr_r;
    status_nxt    = status_r;

    unique case (cw.ld)
      L_NONE:   ;
      L_FLAG:   flag_nxt = rdata;
      L_BS:     bs_nxt = {2'b00, rdata};
      L_BSADD:  bs_nxt = bs_r + {2'b00, rdata} + ADDR_W'(2);
      L_CURADV: cur_nxt = nxt_addr;
      default:  ;
    endcase

    if (cw.cond == C_DISPATCH) begin
      if (in_acc) begin
        req_nxt = in_request_size;
        if (in_op == OP_FREE) begin
          // header sits two bytes below the payload, modulo 256
          cur_nxt = {2'b00, in_release_address - 8'd2};
          upc_nxt = U_F_CLR;
        end else begin
          cur_nxt = BASE_A;
          upc_nxt = U_A_HDR;
        end
      end
    end else if (cw.cond == C_EMIT) begin
      if (emit_go) begin
        out_valid_nxt = 1'b1;
        unique case (cw.res)
          R_OK: begin
            paddr_nxt  = cur_r[7:0] + 8'd2;
            status_nxt = ST_ALLOCATED;
          end
          R_NOFIT: begin
            paddr_nxt  = '0;
            status_nxt = ST_NO_FIT;
          end
          R_FREED: begin
            paddr_nxt  = '0;
            status_nxt = ST_FREED;
          end
          default: begin
            paddr_nxt  = '0;
            status_nxt = ST_FREED;
          end
        endcase
        upc_nxt = U_IDLE;
      end
    end else if (taken) begin
      upc_nxt = cw.target;
    end else begin
      upc_nxt = step_t'(upc_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    bs_r     <= bs_nxt;
    flag_r   <= flag_nxt;
    req_r    <= req_nxt;
    paddr_r  <= paddr_nxt;
    status_r <= status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_payload_address = paddr_r;
  assign out_status          = status_r;

  // a step never reads and writes the heap store together
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.re && mreq.we))
    else $error("heap store read and write in one step");

  // an accepted transaction leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (upc_r != U_IDLE))
    else $error("sequencer stayed idle after accept");

  // a finishing step always leaves a result in the output register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && (upc_r == U_IDLE)))
    else $error("result not captured on emit");

  // a free never reports an address, a failed allocate neither
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FREED || status_r == ST_NO_FIT)) |->
      (paddr_r == 8'd0))
    else $error("nonzero address with free or no-fit status");

endmodule
